// ===== design/eti_pkg.sv =====
`timescale 1ns / 1ps

package eti_pkg;

    // Curve codes
    localparam logic [3:0] MODE_LINEAR      = 4'd0;
    localparam logic [3:0] MODE_IN_QUAD     = 4'd1;
    localparam logic [3:0] MODE_OUT_QUAD    = 4'd2;
    localparam logic [3:0] MODE_INOUT_QUAD  = 4'd3;
    localparam logic [3:0] MODE_IN_CUBIC    = 4'd4;
    localparam logic [3:0] MODE_OUT_CUBIC   = 4'd5;
    localparam logic [3:0] MODE_INOUT_CUBIC = 4'd6;
    localparam logic [3:0] MODE_OUT_BOUNCE  = 4'd7;
    localparam logic [3:0] MODE_IN_ELASTIC  = 4'd8;
    localparam logic [3:0] MODE_OUT_ELASTIC = 4'd9;

    localparam int T_BITS = 16;
    localparam logic signed [19:0] ONE_Q16 = 20'sd65536;

    localparam longint ONE30   = 64'sd1073741824;
    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint LN2_Q30 = 64'sd744261118;

    // Item side-band that travels alongside the quotient
    typedef struct packed {
        logic               valid;
        logic               upd;
        logic               fin;
        logic signed [31:0] start;
        logic signed [31:0] endl;
        logic signed [32:0] diff;
        logic [31:0]        ne;
        logic [3:0]         mode;
    } eti_meta_t;

    // State handed from one divider cell to the next
    typedef struct packed {
        eti_meta_t          meta;
        logic [31:0]        rem;
        logic [31:0]        den;
        logic [T_BITS-1:0]  quo;
    } eti_div_t;

    // term * x^2 in Q30
    function automatic longint sq_step(input longint term, input longint x);
        longint p;
        p = term * x / ONE30;
        return p * x / ONE30;
    endfunction

    // term * y in Q30
    function automatic longint lin_step(input longint term, input longint y);
        return term * y / ONE30;
    endfunction

    // Quarter-wave sine by series, Q16
    function automatic longint sin_quarter(input int bits, input int i);
        longint x;
        longint sum;
        longint term;
        longint v;
        x = (PI_Q30 * 2 * longint'(i)) >>> bits;
        sum = x;
        term = x;
        // odd terms, divisors (2k)(2k+1) for k = 1 to 9
        term = -sq_step(term, x) / 64'sd6;   sum += term;
        term = -sq_step(term, x) / 64'sd20;  sum += term;
        term = -sq_step(term, x) / 64'sd42;  sum += term;
        term = -sq_step(term, x) / 64'sd72;  sum += term;
        term = -sq_step(term, x) / 64'sd110; sum += term;
        term = -sq_step(term, x) / 64'sd156; sum += term;
        term = -sq_step(term, x) / 64'sd210; sum += term;
        term = -sq_step(term, x) / 64'sd272; sum += term;
        term = -sq_step(term, x) / 64'sd342; sum += term;
        if (sum < 0) sum = 0;
        v = (sum + 64'sd8192) / 64'sd16384;
        if (v > 64'sd65536) v = 64'sd65536;
        return v;
    endfunction

    // Full-turn sine table entry
    function automatic logic signed [17:0] sine_entry(input int bits, input int j);
        int     half;
        int     quarter;
        int     jj;
        int     i;
        longint v;
        half = 1 << (bits - 1);
        quarter = 1 << (bits - 2);
        jj = (j >= half) ? j - half : j;
        i = (jj <= quarter) ? jj : half - jj;
        v = sin_quarter(bits, i);
        if (j >= half) v = -v;
        return 18'(v);
    endfunction

    // 2^(-i/N) table entry, Q16
    function automatic logic [16:0] exp_entry(input int bits, input int i);
        longint y;
        longint sum;
        longint term;
        y = (LN2_Q30 * longint'(i)) >>> bits;
        sum = ONE30;
        term = ONE30;
        // series of exp(-y) up to the twelfth power
        term = -lin_step(term, y) / 64'sd1;  sum += term;
        term = -lin_step(term, y) / 64'sd2;  sum += term;
        term = -lin_step(term, y) / 64'sd3;  sum += term;
        term = -lin_step(term, y) / 64'sd4;  sum += term;
        term = -lin_step(term, y) / 64'sd5;  sum += term;
        term = -lin_step(term, y) / 64'sd6;  sum += term;
        term = -lin_step(term, y) / 64'sd7;  sum += term;
        term = -lin_step(term, y) / 64'sd8;  sum += term;
        term = -lin_step(term, y) / 64'sd9;  sum += term;
        term = -lin_step(term, y) / 64'sd10; sum += term;
        term = -lin_step(term, y) / 64'sd11; sum += term;
        term = -lin_step(term, y) / 64'sd12; sum += term;
        return 17'((sum + 64'sd8192) / 64'sd16384);
    endfunction

endpackage

// ===== design/eti_div_cell.sv =====
`timescale 1ns / 1ps

module eti_div_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  eti_pkg::eti_div_t d_in,
    output eti_pkg::eti_div_t d_out
);
    import eti_pkg::*;

    eti_div_t    d_reg;
    eti_div_t    d_next;
    logic [32:0] r2;
    logic        ge;

    // One restoring step: one quotient bit
    always_comb
    begin
        r2 = {d_in.rem, 1'b0};
        ge = (r2 >= {1'b0, d_in.den});
        d_next = d_in;
        d_next.rem = ge ? 32'(r2 - {1'b0, d_in.den}) : r2[31:0];
        d_next.quo = {d_in.quo[T_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg.meta.valid <= 1'b0;
        end
        else if (adv)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== design/eti_ease.sv =====
`timescale 1ns / 1ps

module eti_ease #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int EXP2_TABLE_BITS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  eti_pkg::eti_meta_t         meta_in,
    input  logic [eti_pkg::T_BITS-1:0] t_in,
    output eti_pkg::eti_meta_t         meta_out,
    output logic signed [19:0]         e_out
);
    import eti_pkg::*;

    localparam int NSIN = 1 << SINE_TABLE_BITS;
    localparam int NEXP = 1 << EXP2_TABLE_BITS;

    logic signed [17:0] sin_rom [NSIN];
    logic [16:0]        exp_rom [NEXP];

    for (genvar gi = 0; gi < NSIN; gi++)
    begin : g_sin
        assign sin_rom[gi] = sine_entry(SINE_TABLE_BITS, gi);
    end
    for (genvar gj = 0; gj < NEXP; gj++)
    begin : g_exp
        assign exp_rom[gj] = exp_entry(EXP2_TABLE_BITS, gj);
    end

    // ---------------- stage 1: first product, bounce square, elastic set-up
    logic signed [19:0] t_s, f_s, f2_s, op_a, op_b;
    logic signed [39:0] p1;
    logic signed [23:0] m1_next;
    logic [20:0]        t22;
    logic signed [21:0] g;
    logic signed [43:0] gsq;
    logic [15:0]        h_next;
    logic               el_in;
    logic [16:0]        tc;
    logic [19:0]        kx;
    logic [16:0]        pw_next;
    logic [21:0]        num;
    logic [53:0]        ph;
    logic [15:0]        u;

    eti_meta_t                  s1_meta_reg;
    logic [T_BITS-1:0]          s1_t_reg;
    logic signed [23:0]         s1_m1_reg;
    logic [43:0]                s1_gg_reg;
    logic [15:0]                s1_h_reg;
    logic [16:0]                s1_pw_reg;
    logic [SINE_TABLE_BITS-1:0] s1_sidx_reg;

    always_comb
    begin
        t_s  = signed'({4'b0, t_in});
        f_s  = t_s - ONE_Q16;
        f2_s = (t_s <<< 1) - (ONE_Q16 <<< 1);
        case (meta_in.mode)
            MODE_OUT_QUAD:
            begin
                op_a = t_s;
                op_b = (ONE_Q16 <<< 1) - t_s;
            end
            MODE_INOUT_QUAD:
            begin
                op_a = t_in[T_BITS-1] ? (ONE_Q16 <<< 2) - (t_s <<< 1) : t_s;
                op_b = t_s;
            end
            MODE_OUT_CUBIC:
            begin
                op_a = f_s;
                op_b = f_s;
            end
            MODE_INOUT_CUBIC:
            begin
                op_a = t_in[T_BITS-1] ? f2_s : t_s;
                op_b = t_in[T_BITS-1] ? f2_s : t_s;
            end
            default:
            begin
                op_a = t_s;
                op_b = t_s;
            end
        endcase
        p1 = op_a * op_b;
        m1_next = 24'((p1 + 40'sd32768) >>> 16);

        // bounce segments
        t22 = 21'(t_in) * 21'd22;
        if (t22 < 21'd524288)
        begin
            g = signed'({1'b0, t22});
            h_next = 16'd0;
        end
        else if (t22 < 21'd1048576)
        begin
            g = signed'({1'b0, t22}) - 22'sd786432;
            h_next = 16'd49152;
        end
        else if (t22 < 21'd1310720)
        begin
            g = signed'({1'b0, t22}) - 22'sd1179648;
            h_next = 16'd61440;
        end
        else
        begin
            g = signed'({1'b0, t22}) - 22'sd1376256;
            h_next = 16'd64512;
        end
        gsq = g * g;

        // elastic: decay and sine phase (divide by three via reciprocal)
        el_in = (meta_in.mode == MODE_IN_ELASTIC);
        tc = 17'd65536 - {1'b0, t_in};
        kx = el_in ? 20'(tc) * 20'd10 : 20'(t_in) * 20'd10;
        pw_next = exp_rom[kx[15 -: EXP2_TABLE_BITS]] >> kx[19:16];
        num = el_in ? 22'(t_in) * 22'd10 + 22'd2441216
                    : 22'(t_in) * 22'd10 + 22'd3096576;
        ph = 54'(num) * 54'd2863311531;
        u = ph[48:33];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_meta_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            s1_meta_reg <= meta_in;
            s1_t_reg    <= t_in;
            s1_m1_reg   <= m1_next;
            s1_gg_reg   <= unsigned'(gsq);
            s1_h_reg    <= h_next;
            s1_pw_reg   <= pw_next;
            s1_sidx_reg <= u[15 -: SINE_TABLE_BITS];
        end
    end

    // ---------------- stage 2: second product, bounce finish
    logic signed [19:0] t2_s, f2a_s, f2b_s, op_d;
    logic signed [23:0] op_c;
    logic signed [43:0] p2;
    logic signed [23:0] m2_next;
    logic signed [17:0] sin_v;
    logic [16:0]        bnc_next;

    eti_meta_t          s2_meta_reg;
    logic [T_BITS-1:0]  s2_t_reg;
    logic signed [23:0] s2_m1_reg;
    logic signed [23:0] s2_m2_reg;
    logic [16:0]        s2_bnc_reg;

    always_comb
    begin
        t2_s  = signed'({4'b0, s1_t_reg});
        f2a_s = t2_s - ONE_Q16;
        f2b_s = (t2_s <<< 1) - (ONE_Q16 <<< 1);
        sin_v = sin_rom[s1_sidx_reg];
        op_c = s1_m1_reg;
        case (s1_meta_reg.mode)
            MODE_OUT_CUBIC:   op_d = f2a_s;
            MODE_INOUT_CUBIC: op_d = s1_t_reg[T_BITS-1] ? f2b_s : t2_s;
            MODE_IN_ELASTIC, MODE_OUT_ELASTIC:
            begin
                op_c = signed'({7'b0, s1_pw_reg});
                op_d = signed'({{2{sin_v[17]}}, sin_v});
            end
            default:          op_d = t2_s;
        endcase
        p2 = op_c * op_d;
        m2_next = 24'((p2 + 44'sd32768) >>> 16);
        bnc_next = 17'((s1_gg_reg + 44'd2097152) >> 22) + 17'(s1_h_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_meta_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            s2_meta_reg <= s1_meta_reg;
            s2_t_reg    <= s1_t_reg;
            s2_m1_reg   <= s1_m1_reg;
            s2_m2_reg   <= m2_next;
            s2_bnc_reg  <= bnc_next;
        end
    end

    // ---------------- stage 3: curve result select
    logic signed [19:0] m1e, m2e, t3_s, e_next;
    logic               lo;
    logic               tz;

    eti_meta_t          s3_meta_reg;
    logic signed [19:0] s3_e_reg;

    always_comb
    begin
        lo   = !s2_t_reg[T_BITS-1];
        tz   = (s2_t_reg == '0);
        t3_s = signed'({4'b0, s2_t_reg});
        m1e  = 20'(s2_m1_reg);
        m2e  = 20'(s2_m2_reg);
        case (s2_meta_reg.mode)
            MODE_IN_QUAD, MODE_OUT_QUAD: e_next = m1e;
            MODE_INOUT_QUAD:  e_next = lo ? (m1e <<< 1) : m1e - ONE_Q16;
            MODE_IN_CUBIC:    e_next = m2e;
            MODE_OUT_CUBIC:   e_next = m2e + ONE_Q16;
            MODE_INOUT_CUBIC:
                e_next = lo ? (m2e <<< 2) : ((m2e + 20'sd1) >>> 1) + ONE_Q16;
            MODE_OUT_BOUNCE:  e_next = signed'({3'b0, s2_bnc_reg});
            MODE_IN_ELASTIC:  e_next = tz ? 20'sd0 : -m2e;
            MODE_OUT_ELASTIC: e_next = tz ? 20'sd0 : m2e + ONE_Q16;
            default:          e_next = t3_s;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_meta_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            s3_meta_reg <= s2_meta_reg;
            s3_e_reg    <= e_next;
        end
    end

    assign meta_out = s3_meta_reg;
    assign e_out    = s3_e_reg;

endmodule

// ===== design/eased_tween_interpolator_unit.sv =====
`timescale 1ns / 1ps
// Eased tween interpolator: one input item is one tween update.
// Input channel (in_valid/in_ready) carries start and end level, elapsed
// time, duration, step and curve mode; output channel (out_valid/out_ready)
// returns the new elapsed time, the eased level, level_valid and finished.
// cfg_we/cfg_data write the maximum step; write only while the block is idle.
// Throughput: one item per cycle, unless the receiver stalls the output.
// Progress is found by a row of sixteen divider cells, one quotient bit each,
// followed by three curve stages, a scaling multiply and the output register.
// The whole pipeline advances together whenever the output register is empty
// or its item is being taken; when the receiver stalls with the output full,
// in_ready drops and every stage holds, so nothing is lost or repeated.
// Reset clears all stage valid flags and loads the maximum step with 100000.
module eased_tween_interpolator_unit #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int EXP2_TABLE_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] start_level,
    input  logic signed [31:0] end_level,
    input  logic [31:0]        elapsed_us,
    input  logic [31:0]        duration_us,
    input  logic [31:0]        step_us,
    input  logic [3:0]         curve_mode,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        new_elapsed_us,
    output logic signed [31:0] level_out,
    output logic               level_valid,
    output logic               finished,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data
);
    import eti_pkg::*;

    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Maximum step register
    logic [31:0] max_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg <= 32'd100000;
        end
        else if (cfg_we)
        begin
            max_step_reg <= cfg_data;
        end
    end

    // Stage 0: capture item, clamp step
    logic               s0_valid_reg;
    logic signed [31:0] s0_start_reg;
    logic signed [31:0] s0_end_reg;
    logic [31:0]        s0_el_reg;
    logic [31:0]        s0_du_reg;
    logic [31:0]        s0_st_reg;
    logic               s0_zero_reg;
    logic [3:0]         s0_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
            s0_start_reg <= start_level;
            s0_end_reg   <= end_level;
            s0_el_reg    <= elapsed_us;
            s0_du_reg    <= duration_us;
            s0_st_reg    <= (step_us > max_step_reg) ? max_step_reg : step_us;
            s0_zero_reg  <= (step_us == 32'd0);
            s0_mode_reg  <= curve_mode;
        end
    end

    // Stage 1: advance elapsed time, saturate, seed divider
    logic [32:0] sum;
    logic [31:0] ne;
    eti_div_t    s1_next;
    eti_div_t    s1_div_reg;

    always_comb
    begin
        sum = {1'b0, s0_el_reg} + {1'b0, s0_st_reg};
        ne  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        s1_next.meta.valid = s0_valid_reg;
        s1_next.meta.upd   = !s0_zero_reg;
        s1_next.meta.fin   = !s0_zero_reg && (ne >= s0_du_reg);
        s1_next.meta.start = s0_start_reg;
        s1_next.meta.endl  = s0_end_reg;
        s1_next.meta.diff  = {s0_end_reg[31], s0_end_reg}
                           - {s0_start_reg[31], s0_start_reg};
        s1_next.meta.ne    = ne;
        s1_next.meta.mode  = s0_mode_reg;
        s1_next.rem        = ne;
        s1_next.den        = s0_du_reg;
        s1_next.quo        = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_div_reg.meta.valid <= 1'b0;
        end
        else if (adv)
        begin
            s1_div_reg <= s1_next;
        end
    end

    // Divider row: progress in Q0.16
    eti_div_t chain [T_BITS+1];

    assign chain[0] = s1_div_reg;

    for (genvar gc = 0; gc < T_BITS; gc++)
    begin : g_cell
        eti_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .d_in  (chain[gc]),
            .d_out (chain[gc+1])
        );
    end

    // Curve stages
    eti_meta_t          ease_meta;
    logic signed [19:0] ease_e;

    eti_ease #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .EXP2_TABLE_BITS (EXP2_TABLE_BITS)
    ) u_ease (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .meta_in  (chain[T_BITS].meta),
        .t_in     (chain[T_BITS].quo),
        .meta_out (ease_meta),
        .e_out    (ease_e)
    );

    // Stage 4: scale span by eased value
    logic signed [52:0] prod;
    eti_meta_t          e4_meta_reg;
    logic signed [36:0] e4_q_reg;

    assign prod = ease_meta.diff * ease_e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e4_meta_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            e4_meta_reg <= ease_meta;
            e4_q_reg    <= 37'((prod + 53'sd32768) >>> 16);
        end
    end

    // Output register: offset, saturate, select
    logic signed [37:0] lvl;
    logic signed [31:0] lvl_sat;
    logic [31:0]        new_elapsed_reg;
    logic signed [31:0] level_reg;
    logic               level_valid_reg;
    logic               finished_reg;

    always_comb
    begin
        lvl = 38'(e4_q_reg) + 38'(e4_meta_reg.start);
        if (lvl > 38'sd2147483647)
            lvl_sat = 32'sh7FFF_FFFF;
        else if (lvl < -38'sd2147483648)
            lvl_sat = 32'sh8000_0000;
        else
            lvl_sat = 32'(lvl);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg   <= e4_meta_reg.valid;
            new_elapsed_reg <= e4_meta_reg.ne;
            level_valid_reg <= e4_meta_reg.upd;
            finished_reg    <= e4_meta_reg.fin;
            if (!e4_meta_reg.upd)
                level_reg <= 32'sd0;
            else if (e4_meta_reg.fin)
                level_reg <= e4_meta_reg.endl;
            else
                level_reg <= lvl_sat;
        end
    end

    assign out_valid      = out_valid_reg;
    assign new_elapsed_us = new_elapsed_reg;
    assign level_out      = level_reg;
    assign level_valid    = level_valid_reg;
    assign finished       = finished_reg;

endmodule
